// ----- rtl/awlp_pkg.sv -----
// Package for the ASCII weight line parser: character codes, fixed field
// widths and the result record passed between the parser and the output stage.
// No dependencies.
`default_nettype none
package awlp_pkg;

	// Field widths of the result, fixed by the output format
	localparam int MANT_OUT_W = 32;
	localparam int FRAC_W     = 5;
	localparam int LEN_W      = 7;
	localparam int BYTE_W     = 8;

	// Fraction digit counter stops here
	localparam logic [FRAC_W-1:0] FRAC_MAX = 5'd31;

	// Character codes
	localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CHAR_POINT = 8'h2E;
	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

	typedef struct packed {
		logic signed [MANT_OUT_W-1:0] weight_mantissa;
		logic [FRAC_W-1:0]            fraction_digits;
		logic                         parse_ok;
		logic                         mantissa_saturated;
		logic [LEN_W-1:0]             frame_length;
	} result_t;

endpackage
`default_nettype wire

// ----- rtl/awlp_byte_if.sv -----
// Byte channel into the parser: valid/ready handshake with one received byte.
// Depends on awlp_pkg for the byte width.
`default_nettype none
interface awlp_byte_if;
	logic                          valid;
	logic                          ready;
	logic [awlp_pkg::BYTE_W-1:0]   rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/awlp_result_if.sv -----
// Result channel out of the parser: valid/ready handshake with the parsed weight.
// Depends on awlp_pkg for the field widths.
`default_nettype none
interface awlp_result_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [awlp_pkg::MANT_OUT_W-1:0]  weight_mantissa;
	logic [awlp_pkg::FRAC_W-1:0]             fraction_digits;
	logic                                    parse_ok;
	logic                                    mantissa_saturated;
	logic [awlp_pkg::LEN_W-1:0]              frame_length;

	modport source (output valid, output weight_mantissa, output fraction_digits,
		output parse_ok, output mantissa_saturated, output frame_length, input ready);
	modport sink   (input valid, input weight_mantissa, input fraction_digits,
		input parse_ok, input mantissa_saturated, input frame_length, output ready);
endinterface
`default_nettype wire

// ----- rtl/ascii_weight_line_parser_core.sv -----
// ASCII weight line parser. Takes one received UART byte per transaction on rx
// and gives one transaction on result for every newline-terminated line that
// holds a non-whitespace byte: the decimal reading as a signed mantissa with a
// count of fraction digits, a parse flag, a saturation flag and the trimmed line
// length. The block takes one byte every clock cycle unless a newline is held
// back; the rate is set by the update of the line state, whose widest path is
// the multiply by ten and add of the digit accumulator. A result is loaded into
// the result register as its newline leaves the input register. Bytes keep flowing
// while a result waits to be taken; only a newline that closes a non-blank line is
// held back, and only while the result register is still full. Carriage returns are
// ignored; a line that reaches LINE_BYTES-1 stored bytes is dropped together with the
// byte that overflowed it. Depends on awlp_pkg, awlp_byte_if, awlp_result_if,
// awlp_in_stage, awlp_line_state and awlp_out_stage.
`default_nettype none
module ascii_weight_line_parser_core #(
	parameter int LINE_BYTES    = 128,
	parameter int NUMBER_CHARS  = 32,
	parameter int MANTISSA_BITS = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	awlp_byte_if.sink      rx,
	awlp_result_if.source  result
);

	logic                          valid_s1;
	logic [awlp_pkg::BYTE_W-1:0]   byte_s1;
	logic                          take;
	logic                          emit;
	logic                          out_free;
	awlp_pkg::result_t             line_result;

	// Input register: holds the accepted byte for one pass through the line state
	awlp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// Line state: advance counters and accumulator, form the result at the newline
	awlp_line_state #(
		.LINE_BYTES    (LINE_BYTES),
		.NUMBER_CHARS  (NUMBER_CHARS),
		.MANTISSA_BITS (MANTISSA_BITS)
	) u_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.out_free (out_free),
		.take     (take),
		.emit     (emit),
		.result   (line_result)
	);

	// Result register: load only when a result-bearing newline is taken
	awlp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (emit && take),
		.result_d (line_result),
		.free     (out_free),
		.result   (result)
	);

endmodule
`default_nettype wire

// ----- rtl/awlp_in_stage.sv -----
// Input register of the parser: holds one accepted byte until the line state takes it.
// Depends on awlp_pkg and awlp_byte_if.
`default_nettype none
module awlp_in_stage (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	awlp_byte_if.sink                        rx,
	input  wire logic                        take,
	output logic                             valid_s1,
	output logic [awlp_pkg::BYTE_W-1:0]      byte_s1
);

	// Free when empty, or when the held byte leaves in this cycle
	assign rx.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/awlp_line_state.sv -----
// Running line state: byte count, trim positions and the decimal accumulator.
// Forms the result record at the newline. Depends on awlp_pkg.
`default_nettype none
module awlp_line_state #(
	parameter int LINE_BYTES    = 128,
	parameter int NUMBER_CHARS  = 32,
	parameter int MANTISSA_BITS = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        valid_s1,
	input  wire logic [awlp_pkg::BYTE_W-1:0] byte_s1,
	input  wire logic                        out_free,
	output logic                             take,
	output logic                             emit,
	output awlp_pkg::result_t                result
);

	localparam int POS_W  = $clog2(LINE_BYTES);
	localparam int KEPT_W = $clog2(NUMBER_CHARS);
	localparam int MAG_W  = MANTISSA_BITS - 1;
	localparam int PROD_W = MAG_W + 4;
	localparam int EXT_W  = (MAG_W > awlp_pkg::MANT_OUT_W) ? MAG_W : awlp_pkg::MANT_OUT_W;
	localparam int LENC_W = (POS_W + 1 > awlp_pkg::LEN_W) ? POS_W + 1 : awlp_pkg::LEN_W;

	localparam logic [POS_W-1:0]  LINE_LAST = POS_W'(LINE_BYTES - 1);
	localparam logic [KEPT_W-1:0] KEPT_LAST = KEPT_W'(NUMBER_CHARS - 1);
	localparam logic [MAG_W-1:0]  MAG_LIMIT = '1;

	logic [POS_W-1:0]           line_q, line_d;
	logic [KEPT_W-1:0]          kept_q, kept_d;
	logic                       point_q, point_d;
	logic                       digit_q, digit_d;
	logic                       minus_q, minus_d;
	logic [MAG_W-1:0]           mag_q, mag_d;
	logic [awlp_pkg::FRAC_W-1:0] frac_q, frac_d;
	logic                       clamp_q, clamp_d;
	logic [POS_W-1:0]           first_q, first_d;
	logic [POS_W-1:0]           last_q, last_d;
	logic                       content_q, content_d;

	logic                       is_lf, is_cr, is_white, is_digit, can_keep;
	logic [PROD_W-1:0]          prod;
	logic [EXT_W-1:0]           mag_ext, mant_ext;
	logic [LENC_W-1:0]          len_calc;

	assign is_lf    = (byte_s1 == awlp_pkg::CHAR_LF);
	assign is_cr    = (byte_s1 == awlp_pkg::CHAR_CR);
	assign is_white = (byte_s1 == awlp_pkg::CHAR_SPACE) ||
		(byte_s1 >= awlp_pkg::CHAR_TAB && byte_s1 <= awlp_pkg::CHAR_CR);
	assign is_digit = (byte_s1 >= awlp_pkg::CHAR_ZERO) && (byte_s1 <= awlp_pkg::CHAR_NINE);
	assign can_keep = (kept_q != KEPT_LAST);

	// mag*10 + d; overflow past the limit shows in the top four bits
	assign prod = (PROD_W'(mag_q) << 3) + (PROD_W'(mag_q) << 1)
		+ PROD_W'(byte_s1 - awlp_pkg::CHAR_ZERO);

	// Hold a result-bearing newline while the output register is full
	assign emit = valid_s1 && is_lf && (line_q != '0) && content_q;
	assign take = valid_s1 && (!emit || out_free);

	always_comb begin
		line_d    = line_q;
		kept_d    = kept_q;
		point_d   = point_q;
		digit_d   = digit_q;
		minus_d   = minus_q;
		mag_d     = mag_q;
		frac_d    = frac_q;
		clamp_d   = clamp_q;
		first_d   = first_q;
		last_d    = last_q;
		content_d = content_q;
		if (is_lf || (!is_cr && line_q >= LINE_LAST)) begin
			// End of line: clear the line state; overflow: drop the whole line
			line_d    = '0;
			kept_d    = '0;
			point_d   = 1'b0;
			digit_d   = 1'b0;
			minus_d   = 1'b0;
			mag_d     = '0;
			frac_d    = '0;
			clamp_d   = 1'b0;
			first_d   = '0;
			last_d    = '0;
			content_d = 1'b0;
		end else if (!is_cr) begin
			if (!is_white) begin
				if (!content_q) begin
					first_d = line_q;
				end
				last_d    = line_q;
				content_d = 1'b1;
			end
			if (can_keep) begin
				if (is_digit) begin
					if (clamp_q || prod[PROD_W-1:MAG_W] != '0) begin
						mag_d   = MAG_LIMIT;
						clamp_d = 1'b1;
					end else begin
						mag_d = prod[MAG_W-1:0];
					end
					if (point_q && frac_q != awlp_pkg::FRAC_MAX) begin
						frac_d = frac_q + 1'b1;
					end
					digit_d = 1'b1;
					kept_d  = kept_q + 1'b1;
				end else if (byte_s1 == awlp_pkg::CHAR_MINUS && kept_q == '0) begin
					minus_d = 1'b1;
					kept_d  = kept_q + 1'b1;
				end else if ((byte_s1 == awlp_pkg::CHAR_POINT ||
					byte_s1 == awlp_pkg::CHAR_COMMA) && !point_q) begin
					point_d = 1'b1;
					kept_d  = kept_q + 1'b1;
				end
			end
			line_d = line_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q    <= '0;
			kept_q    <= '0;
			point_q   <= 1'b0;
			digit_q   <= 1'b0;
			minus_q   <= 1'b0;
			mag_q     <= '0;
			frac_q    <= '0;
			clamp_q   <= 1'b0;
			first_q   <= '0;
			last_q    <= '0;
			content_q <= 1'b0;
		end else if (take) begin
			line_q    <= line_d;
			kept_q    <= kept_d;
			point_q   <= point_d;
			digit_q   <= digit_d;
			minus_q   <= minus_d;
			mag_q     <= mag_d;
			frac_q    <= frac_d;
			clamp_q   <= clamp_d;
			first_q   <= first_d;
			last_q    <= last_d;
			content_q <= content_d;
		end
	end

	// Result record from the state held before the newline
	assign mag_ext  = EXT_W'(mag_q);
	assign mant_ext = minus_q ? (EXT_W'(0) - mag_ext) : mag_ext;
	assign len_calc = LENC_W'(last_q) - LENC_W'(first_q) + LENC_W'(1);

	always_comb begin
		result.weight_mantissa    = digit_q ? mant_ext[awlp_pkg::MANT_OUT_W-1:0] : '0;
		result.fraction_digits    = digit_q ? frac_q : '0;
		result.parse_ok           = digit_q;
		result.mantissa_saturated = digit_q && clamp_q;
		result.frame_length       = len_calc[awlp_pkg::LEN_W-1:0];
	end

endmodule
`default_nettype wire

// ----- rtl/awlp_out_stage.sv -----
// Result register of the parser: holds one finished line result until taken.
// Depends on awlp_pkg and awlp_result_if.
`default_nettype none
module awlp_out_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  awlp_pkg::result_t  result_d,
	output logic               free,
	awlp_result_if.source      result
);

	logic              valid_q;
	awlp_pkg::result_t data_q;

	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= result_d;
		end
	end

	assign result.valid              = valid_q;
	assign result.weight_mantissa    = data_q.weight_mantissa;
	assign result.fraction_digits    = data_q.fraction_digits;
	assign result.parse_ok           = data_q.parse_ok;
	assign result.mantissa_saturated = data_q.mantissa_saturated;
	assign result.frame_length       = data_q.frame_length;

endmodule
`default_nettype wire
